/* design/gtg_pkg.sv */
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants
// Types, register indexes and the arctangent table for the steering core.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int ZW = 24;  // angle accumulator, 2^-20 rad
  localparam int CW = 28;  // CORDIC x/y width
  localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [17:0] PI_Q12 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic [16:0] SPEED_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    REG_TOL   = 2'd0,
    REG_GAIN  = 2'd1,
    REG_MINT  = 2'd2,
    REG_SGAIN = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_TURN, ST_SQRT, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic cordic_step;
    logic turn_calc;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_req;
    logic cordic_last;
    logic sqrt_last;
    logic div_last;
  } sts_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 24'd823550;   5'd1: r = 24'd486170;
      5'd2: r = 24'd256879;   5'd3: r = 24'd130396;
      5'd4: r = 24'd65451;    5'd5: r = 24'd32757;
      5'd6: r = 24'd16383;    5'd7: r = 24'd8192;
      5'd8: r = 24'd4096;     5'd9: r = 24'd2048;
      5'd10: r = 24'd1024;    5'd11: r = 24'd512;
      5'd12: r = 24'd256;     5'd13: r = 24'd128;
      5'd14: r = 24'd64;      5'd15: r = 24'd32;
      5'd16: r = 24'd16;      5'd17: r = 24'd8;
      5'd18: r = 24'd4;       5'd19: r = 24'd2;
      5'd20: r = 24'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/gtg_ctrl.sv */
// ----------------------------------------------------------------------------
// gtg_ctrl: sequencer
// Steps the datapath through CORDIC, turn, square root and division phases.
// ----------------------------------------------------------------------------
module gtg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          out_free,
  input  gtg_pkg::sts_t sts,
  output gtg_pkg::cmd_t cmd,
  output logic          busy
);
  import gtg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (sts.clear_req) state_nxt = ST_DONE;
        else if (sts.cordic_last) state_nxt = ST_TURN;
      end
      ST_TURN:   state_nxt = ST_SQRT;
      ST_SQRT:   if (sts.sqrt_last) state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.load = start;
      ST_CORDIC: cmd.cordic_step = !sts.clear_req;
      ST_TURN:   cmd.turn_calc = 1'b1;
      ST_SQRT:   begin
        cmd.sqrt_step = 1'b1;
        cmd.div_load = sts.sqrt_last;
      end
      ST_DIV:    cmd.div_step = 1'b1;
      ST_DONE:   cmd.finish = out_free;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
endmodule

/* design/gtg_dp.sv */
// ----------------------------------------------------------------------------
// gtg_dp: datapath
// Differences, arrival check, CORDIC bearing, turn, isqrt and serial divide.
// ----------------------------------------------------------------------------
module gtg_dp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gtg_pkg::cmd_t cmd,
  output gtg_pkg::sts_t sts,
  input  logic          in_func,
  input  logic [15:0]   in_px,
  input  logic [15:0]   in_py,
  input  logic [14:0]   in_hd,
  input  logic [15:0]   in_tx,
  input  logic [15:0]   in_ty,
  input  logic [9:0]    tol,
  input  logic [7:0]    gain,
  input  logic [15:0]   min_turn,
  input  logic [15:0]   sgain,
  output logic [16:0]   res_turn,
  output logic [16:0]   res_speed,
  output logic          res_within,
  output logic [1:0]    res_stage
);
  import gtg_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0] it_r;
  logic signed [14:0] hd_r;
  logic func_r;
  logic [16:0] adx_r, ady_r;
  logic [1:0] stage_r;
  logic signed [16:0] turn_r;
  logic [16:0] dmag_r;
  logic [33:0] rad_r;
  logic [16:0] root_r;
  logic [33:0] rem_r;
  logic [4:0] sq_r;
  logic [32:0] num_r;
  logic [16:0] den_r;
  logic [17:0] drem_r;
  logic [5:0] dv_r;
  logic zero_div_r;
  logic big_r;

  // input differences
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  assign dx = 17'(signed'(in_tx)) - 17'(signed'(in_px));
  assign dy = 17'(signed'(in_ty)) - 17'(signed'(in_py));
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);

  logic in_tol;
  assign in_tol = (adx <= {7'd0, tol}) && (ady <= {7'd0, tol});

  // CORDIC step
  logic signed [CW-1:0] xs, ys;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  // turn
  logic signed [17:0] err0, err;
  logic signed [27:0] prod;
  logic signed [23:0] tsh;
  logic signed [ZW-1:0] zr;
  assign zr = (z_r + ZW'(128)) >>> 8;
  assign err0 = 18'(zr) - 18'(hd_r);
  always_comb begin
    err = err0;
    if (err0 < -PI_Q12) err = err0 + TWO_PI_Q12;
    else if (err0 > PI_Q12) err = err0 - TWO_PI_Q12;
  end
  assign prod = 28'(signed'({1'b0, gain})) * 28'(err) + 28'sd8;
  assign tsh = 24'(prod >>> 4);

  // isqrt: two bits per step
  logic [33:0] trial;
  logic [35:0] rem_sh;
  assign rem_sh = {rem_r, rad_r[33:32]};
  assign trial = {15'd0, root_r, 2'b01};

  // divide step
  logic [17:0] dsh;
  assign dsh = {drem_r[16:0], num_r[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 2'd0;
    end else begin
      if (cmd.load) begin
        if (in_func) stage_r <= 2'd0;
        else if (in_tol && stage_r != 2'd3) stage_r <= stage_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      hd_r <= signed'(in_hd);
      adx_r <= adx;
      ady_r <= ady;
      res_within <= in_tol && !in_func;
      it_r <= '0;
      if (dx[16]) begin
        x_r <= -(CW'(dx) <<< 8);
        y_r <= -(CW'(dy) <<< 8);
        z_r <= dy[16] ? -PI_Q20 : PI_Q20;
      end else begin
        x_r <= CW'(dx) <<< 8;
        y_r <= CW'(dy) <<< 8;
        z_r <= '0;
      end
    end
    if (cmd.cordic_step) begin
      it_r <= it_r + 5'd1;
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + signed'(atan_lut(it_r));
      end else if (y_r < 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - signed'(atan_lut(it_r));
      end
    end
    if (cmd.turn_calc) begin
      logic signed [16:0] t;
      logic [16:0] m;
      if (tsh > 24'sd65535) t = 17'sd65535;
      else if (tsh < -24'sd65536) t = -17'sd65536;
      else t = 17'(tsh);
      m = t[16] ? 17'(-t) : 17'(t);
      turn_r <= t;
      dmag_r <= m;
      rad_r <= 34'(adx_r) * 34'(adx_r) + 34'(ady_r) * 34'(ady_r);
      root_r <= '0;
      rem_r <= '0;
      sq_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_r <= sq_r + 5'd1;
      rad_r <= rad_r << 2;
      if (rem_sh[33:0] >= trial && rem_sh[35:34] == 2'b00) begin
        rem_r <= rem_sh[33:0] - trial;
        root_r <= {root_r[15:0], 1'b1};
      end else if (rem_sh[35:34] != 2'b00) begin
        rem_r <= 34'(rem_sh - 36'(trial));
        root_r <= {root_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh[33:0];
        root_r <= {root_r[15:0], 1'b0};
      end
    end
    if (cmd.div_load) begin
      logic [16:0] r;
      logic [16:0] d;
      r = {root_r[15:0], (rem_sh[35:34] != 2'b00) || (rem_sh[33:0] >= trial)};
      d = (dmag_r < {1'b0, min_turn}) ? {1'b0, min_turn} : dmag_r;
      num_r <= 33'(sgain) * 33'(r);
      den_r <= d;
      zero_div_r <= (d == 17'd0);
      drem_r <= '0;
      dv_r <= '0;
      big_r <= 1'b0;
    end
    if (cmd.div_step) begin
      dv_r <= dv_r + 6'd1;
      if (dsh >= {1'b0, den_r}) begin
        drem_r <= dsh - {1'b0, den_r};
        num_r <= {num_r[31:0], 1'b1};
        if (dv_r < 6'd16) big_r <= 1'b1;
      end else begin
        drem_r <= dsh;
        num_r <= {num_r[31:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (func_r) begin
      res_turn = '0;
      res_speed = '0;
    end else begin
      res_turn = turn_r;
      res_speed = (zero_div_r || big_r) ? SPEED_MAX : num_r[16:0];
    end
  end
  assign res_stage = stage_r;

  assign sts.clear_req = func_r;
  assign sts.cordic_last = (it_r == 5'(NSTEP - 1));
  assign sts.sqrt_last = (sq_r == 5'd16);
  assign sts.div_last = (dv_r == 6'd32);
endmodule

/* design/go_to_goal_steering_controller_core.sv */
// ----------------------------------------------------------------------------
// go_to_goal_steering_controller_core: go-to-goal steering top level
// Proportional heading control with distance-scaled forward speed.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser=func, tdata=px,py,heading,tx,ty
// out_    | out | out_tvalid/tready  | tdata=turn,speed,within,stage
// cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
// Phases: an item runs the CORDIC loop, the root steps and the divide steps;
// a clear request skips the turn, root and divide steps. One item at a time.
// Reset: synchronous active-low, registers to their defaults, counter to zero.
// Stalls: result is held in the output register until out_tready.
module go_to_goal_steering_controller_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // pose_x, pose_y, pose_heading, target_x, target_y
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // turn_rate, forward_speed, within_tolerance, arrival_stage
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gtg_pkg::*;

  logic [9:0] tol_r;
  logic [7:0] gain_r;
  logic [15:0] mint_r, sgain_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, start, out_free;
  logic ovalid_r;
  logic [39:0] odata_r;
  logic [16:0] r_turn, r_speed;
  logic r_within;
  logic [1:0] r_stage;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 10'd10;
      gain_r <= 8'd80;
      mint_r <= 16'd2048;
      sgain_r <= 16'd2048;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOL:   tol_r <= cfg_data[9:0];
        REG_GAIN:  gain_r <= cfg_data[7:0];
        REG_MINT:  mint_r <= cfg_data;
        REG_SGAIN: sgain_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign start = in_tvalid && !busy;
  assign out_free = !ovalid_r || out_tready;

  gtg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  gtg_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_tuser), .in_px(in_tdata[15:0]), .in_py(in_tdata[31:16]),
    .in_hd(in_tdata[46:32]), .in_tx(in_tdata[62:47]), .in_ty(in_tdata[78:63]),
    .tol(tol_r), .gain(gain_r), .min_turn(mint_r), .sgain(sgain_r),
    .res_turn(r_turn), .res_speed(r_speed), .res_within(r_within),
    .res_stage(r_stage)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.finish) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) odata_r <= {3'd0, r_stage, r_within, r_speed, r_turn};
  end
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
endmodule

/* design/gtg_checker.sv */
// ----------------------------------------------------------------------------
// gtg_checker: port-level checks
// Watches the ports of the steering core.
// ----------------------------------------------------------------------------
module gtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:37] == 3'd0)
    else $error("padding not zero");
  // a hit on the tolerance always leaves the arrival counter above zero
  a_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[36:35] != 2'd0)
    else $error("arrival stage zero on a tolerance hit");
endmodule

bind go_to_goal_steering_controller_core gtg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* test/tb_go_to_goal_steering_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_go_to_goal_steering_controller_core: steering core testbench
// Drives pose/goal items with random valid gaps and result backpressure, and
// checks every result against a bit-accurate predictor. It covers a directed
// table, several register settings including the extremes, and random items.
// ----------------------------------------------------------------------------
module tb_go_to_goal_steering_controller_core;
  import gtg_pkg::*;

  localparam int STEPS = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // pose_x, pose_y, pose_heading, target_x, target_y
  logic        in_tuser = 1'b0; // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // turn_rate, forward_speed, within_tolerance, arrival_stage
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  go_to_goal_steering_controller_core #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // packed from the top bit down: stage, tolerance hit, speed, turn
  typedef struct packed {
    logic [1:0]  stage;
    logic        tol_hit;
    logic [16:0] speed;
    logic [16:0] turn;
  } cmd_out_t;

  // predictor state
  logic [9:0]  tol_q;
  logic [7:0]  gain_q;
  logic [15:0] mint_q;
  logic [15:0] sgain_q;
  logic [1:0]  arrive_cnt;

  cmd_out_t expected_cmds[$];
  bit       failed = 1'b0;
  bit       calm = 1'b0;  // stretch without idling
  int       n_sent = 0;

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, xs, ys;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (dx < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? 3294199 : -3294199;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_lut(i[4:0]));
      end else if (y < 0) begin
        x -= ys; y += xs; z -= longint'(atan_lut(i[4:0]));
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint root(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 40;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cmd_out_t steer_cmd(logic fn, logic [79:0] d);
    cmd_out_t c;
    longint dx, dy, adx, ady, err, turn, mag, dv, span, spd;
    c = '0;
    if (fn) begin
      arrive_cnt = 2'd0;
      return c;
    end
    dx = longint'($signed(d[62:47])) - longint'($signed(d[15:0]));
    dy = longint'($signed(d[78:63])) - longint'($signed(d[31:16]));
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    c.tol_hit = (adx <= tol_q) && (ady <= tol_q);
    if (c.tol_hit && arrive_cnt != 2'd3) arrive_cnt++;
    err = bearing(dx, dy) - longint'($signed(d[46:32]));
    if (err < -12868) err += 25736;
    else if (err > 12868) err -= 25736;
    turn = (longint'(gain_q) * err + 8) >>> 4;
    if (turn > 65535) turn = 65535;
    if (turn < -65536) turn = -65536;
    mag = turn < 0 ? -turn : turn;
    dv = mag < mint_q ? longint'(mint_q) : mag;
    span = root(adx * adx + ady * ady);
    if (dv == 0) spd = 131071;
    else begin
      spd = longint'(sgain_q) * span / dv;
      if (spd > 131071) spd = 131071;
    end
    c.turn = turn[16:0];
    c.speed = spd[16:0];
    c.stage = arrive_cnt;
    return c;
  endfunction

  // item: func, px, py, heading, tx, ty
  task automatic send_item(logic fn, logic [15:0] px, logic [15:0] py, logic [14:0] hd,
                           logic [15:0] tx, logic [15:0] ty);
    logic [79:0] d;
    d = {1'b0, ty, tx, hd, py, px};
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_cmds.push_back(steer_cmd(fn, d));
    n_sent++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TOL:   tol_q = val[9:0];
      REG_GAIN:  gain_q = val[7:0];
      REG_MINT:  mint_q = val;
      REG_SGAIN: sgain_q = val;
    endcase
  endtask

  task automatic set_regs(logic [15:0] t, logic [15:0] g, logic [15:0] m, logic [15:0] s);
    write_reg(REG_TOL, t);
    write_reg(REG_GAIN, g);
    write_reg(REG_MINT, m);
    write_reg(REG_SGAIN, s);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_item();
    logic [15:0] px, py, tx, ty;
    logic [14:0] hd;
    int k;
    px = $urandom;
    py = $urandom;
    k = $urandom_range(9);
    hd = (k == 0) ? 15'($urandom) : 15'($signed($urandom_range(25736)) - 12868);
    // near goals in four of ten so arrival counter moves; the rest farther or anywhere
    if (k < 4) begin
      tx = px + 16'($signed($urandom_range(40)) - 20);
      ty = py + 16'($signed($urandom_range(40)) - 20);
    end else if (k < 7) begin
      tx = px + 16'($signed($urandom_range(4000)) - 2000);
      ty = py + 16'($signed($urandom_range(4000)) - 2000);
    end else begin
      tx = $urandom;
      ty = $urandom;
    end
    send_item($urandom_range(15) == 0, px, py, hd, tx, ty);
  endtask

  // directed rows: func, px, py, heading, tx, ty
  typedef struct {
    logic        fn;
    logic [15:0] px, py;
    logic [14:0] hd;
    logic [15:0] tx, ty;
  } row_t;

  row_t dir_rows[] = '{
    '{1'b1, 16'h1234, 16'h8000, 15'h1234, 16'h7FFF, 16'h0000},
    '{1'b0, 16'd0, 16'd0, 15'd0, 16'd0, 16'd0},
    '{1'b0, 16'd0, 16'd0, 15'd0, 16'd5, 16'd3},
    '{1'b0, 16'd0, 16'd0, 15'd0, 16'd10, 16'hFFF6},
    '{1'b0, 16'd100, 16'd100, 15'd0, 16'd100, 16'd100},
    '{1'b0, 16'd100, 16'd100, 15'd0, 16'd100, 16'd100},
    '{1'b1, 16'd0, 16'd0, 15'd0, 16'd0, 16'd0},
    '{1'b0, 16'h8000, 16'h8000, 15'd12868, 16'h7FFF, 16'h7FFF},
    '{1'b0, 16'h7FFF, 16'h7FFF, 15'h4DBC, 16'h8000, 16'h8000},
    '{1'b0, 16'h7FFF, 16'h0000, 15'd0, 16'h8000, 16'h0000},
    '{1'b0, 16'd0, 16'd0, 15'h7FFF, 16'hFC00, 16'd1},
    '{1'b0, 16'd0, 16'd0, 15'h4000, 16'hFC00, 16'hFFFF},
    '{1'b0, 16'd0, 16'h8000, 15'h3FFF, 16'd0, 16'h7FFF},
    '{1'b0, 16'd0, 16'h7FFF, 15'h4000, 16'd0, 16'h8000},
    '{1'b0, 16'h5555, 16'hAAAA, 15'h2AAA, 16'hAAAA, 16'h5555},
    '{1'b0, 16'hAAAA, 16'h5555, 15'h5555, 16'h5555, 16'hAAAA}
  };

  // result side
  always @(posedge clk) begin
    cmd_out_t got, exp_c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[36:0];
        if (expected_cmds.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata);
          failed = 1'b1;
        end else begin
          exp_c = expected_cmds.pop_front();
          if (got.turn !== exp_c.turn) begin
            $error("turn_rate exp %h got %h", exp_c.turn, got.turn); failed = 1'b1;
          end
          if (got.speed !== exp_c.speed) begin
            $error("forward_speed exp %h got %h", exp_c.speed, got.speed); failed = 1'b1;
          end
          if (got.tol_hit !== exp_c.tol_hit) begin
            $error("within_tolerance exp %b got %b", exp_c.tol_hit, got.tol_hit);
            failed = 1'b1;
          end
          if (got.stage !== exp_c.stage) begin
            $error("arrival_stage exp %d got %d", exp_c.stage, got.stage); failed = 1'b1;
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    tol_q = 10'd10;
    gain_q = 8'd80;
    mint_q = 16'd2048;
    sgain_q = 16'd2048;
    arrive_cnt = 2'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clear request gives all zeros right after reset
    send_item(1'b1, 16'h7FFF, 16'h8000, 15'h1000, 16'h0000, 16'h1111);
    if (expected_cmds[expected_cmds.size()-1] != '0) begin
      $error("clear result exp %h got %h", 37'd0, expected_cmds[expected_cmds.size()-1]);
      failed = 1'b1;
    end
    foreach (dir_rows[i])
      send_item(dir_rows[i].fn, dir_rows[i].px, dir_rows[i].py, dir_rows[i].hd,
                dir_rows[i].tx, dir_rows[i].ty);
    wait_drain();

    // zero divisor: speed saturates when turn is zero
    set_regs(16'd1023, 16'd0, 16'd0, 16'hFFFF);
    send_item(1'b0, 16'd0, 16'd0, 15'd0, 16'd1000, 16'd0);
    send_item(1'b0, 16'd0, 16'd0, 15'd0, 16'd0, 16'd0);
    send_item(1'b0, 16'd0, 16'd0, 15'd0, 16'd500, 16'd500);
    wait_drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(16'd10, 16'd80, 16'd2048, 16'd2048);
        1: set_regs(16'd1023, 16'd255, 16'd1, 16'hFFFF);
        2: set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0);
        3: set_regs(16'h03FF & 16'($urandom), 16'($urandom_range(255)),
                    16'($urandom), 16'($urandom));
        4: set_regs(16'd0, 16'd255, 16'd0, 16'd1);
        default: set_regs(16'd20, 16'd80, 16'd2048, 16'd2048);
      endcase
      calm = (ph == 2);
      repeat (100) rand_item();
      wait_drain();
      calm = 1'b0;
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
